// ===== hw/rtl/lrut_pkg.sv =====
// Shared widths, field positions, action codes and control types of the LRU block cache tracker.
package lrut_pkg;

    // Parameter defaults
    localparam int BLOCK_BYTES_DEF      = 4096;
    localparam int CACHE_SLOTS_DEF      = 16;
    localparam int BLOCK_INDEX_BITS_DEF = 32;

    // Field widths
    localparam int ACTION_W     = 2;
    localparam int BLOCK_NUM_W  = 32;
    localparam int START_W      = 12;
    localparam int COUNT_W      = 13;
    localparam int FETCH_W      = 13;
    localparam int SLOT_FIELD_W = 4;
    localparam int WB_BLOCK_W   = 32;
    localparam int WB_SIZE_W    = 13;

    // Extent width: offset plus count never exceeds 4095 + 8191
    localparam int EXT_W = 14;

    // Stream widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = ACTION_W;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    // Input word layout
    localparam int S_BLOCK_LSB = 0;
    localparam int S_START_LSB = 32;
    localparam int S_COUNT_LSB = 44;
    localparam int S_FETCH_LSB = 57;

    // Result word layout
    localparam int M_SLOT_LSB = 0;
    localparam int M_WBB_LSB  = 4;
    localparam int M_WBS_LSB  = 36;
    localparam int M_HIT_BIT  = 0;
    localparam int M_WBV_BIT  = 1;

    // Action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FLUSH = 2'd2
    } act_t;

    // Command to the recency table
    typedef struct packed {
        logic promote;  // make cmd_slot most recent and mark it used
        logic alloc;    // cmd_slot is a newly taken free slot
        logic clear;    // free every slot
    } rcy_cmd_t;

endpackage

// ===== hw/rtl/lrut_recency.sv =====
// Recency ranks, used bits and occupancy of the cache slots, with slot searches.
module lrut_recency #(
    parameter int CACHE_SLOTS = lrut_pkg::CACHE_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lrut_pkg::rcy_cmd_t             cmd,
    input  logic [$clog2(CACHE_SLOTS)-1:0] cmd_slot,
    input  logic [$clog2(CACHE_SLOTS)-1:0] find_rank,
    input  logic [$clog2(CACHE_SLOTS)-1:0] probe_slot,
    output logic                           free_found,
    output logic [$clog2(CACHE_SLOTS)-1:0] free_slot,
    output logic [$clog2(CACHE_SLOTS)-1:0] lru_slot,
    output logic [$clog2(CACHE_SLOTS)-1:0] rank_slot,
    output logic                           probe_used,
    output logic                           occ_zero,
    output logic [$clog2(CACHE_SLOTS)-1:0] last_rank
);
    import lrut_pkg::*;

    localparam int SLOT_W = $clog2(CACHE_SLOTS);
    localparam int OCC_W  = $clog2(CACHE_SLOTS + 1);

    logic [CACHE_SLOTS-1:0] used_reg;
    logic [SLOT_W-1:0]      rank_reg [CACHE_SLOTS];
    logic [OCC_W-1:0]       occ_reg;
    logic [SLOT_W-1:0]      limit;

    assign occ_zero   = (occ_reg == '0);
    assign last_rank  = SLOT_W'(occ_reg - OCC_W'(1));
    assign probe_used = used_reg[probe_slot];
    assign limit      = rank_reg[cmd_slot];

    // Slot searches: lowest free slot, least recent slot, slot of a given rank
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        lru_slot   = '0;
        rank_slot  = '0;
        for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
        for (int i = 0; i < CACHE_SLOTS; i++) begin
            if (used_reg[i] && rank_reg[i] == last_rank) begin
                lru_slot = lru_slot | SLOT_W'(i);
            end
            if (used_reg[i] && rank_reg[i] == find_rank) begin
                rank_slot = rank_slot | SLOT_W'(i);
            end
        end
    end

    // Used bits and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            occ_reg  <= '0;
        end else if (cmd.clear) begin
            used_reg <= '0;
            occ_reg  <= '0;
        end else if (cmd.promote) begin
            used_reg[cmd_slot] <= 1'b1;
            if (cmd.alloc) begin
                occ_reg <= occ_reg + OCC_W'(1);
            end
        end
    end

    // Rank cells: promoted slot to rank 0, more recent ones age by one (every used slot on an alloc)
    always_ff @(posedge aclk) begin
        if (cmd.promote) begin
            for (int i = 0; i < CACHE_SLOTS; i++) begin
                if (SLOT_W'(i) == cmd_slot) begin
                    rank_reg[i] <= '0;
                end else if (used_reg[i] && (cmd.alloc || rank_reg[i] < limit)) begin
                    rank_reg[i] <= rank_reg[i] + SLOT_W'(1);
                end
            end
        end
    end

endmodule

// ===== hw/rtl/lru_block_cache_tracker.sv =====
// Top level of the fully associative write-back LRU block cache tracker.
//
// Usage: one word on the s_ channel is a read, write or flush of one file block;
// the action code rides on s_tuser. Read and write words return exactly one
// result word with m_tlast high. A flush returns one write-back word per cached
// block, most recent first, m_tlast on the final one, then empties the cache; a
// flush of an empty cache returns a single all-zero word with m_tlast high.
// Action code 3 is taken and dropped.
// Timing: tags live in a small RAM that one comparator sweeps, one slot
// per cycle. An access sweeps every slot in ST_SCAN; in ST_UPDATE it registers
// its result once the last comparison is done and the output register is free.
// The block takes no new word before then. A flush handles each cached block by
// a rank search, then a RAM read. s_tready is high only while the block is idle.
// Reset: used bits and occupancy clear, the cache is empty at once; tag and
// extent RAM contents are not cleared.
// Stall: a result waits in the output register while m_tready is low; the block
// still takes the next word but holds its own result until the register frees.
module lru_block_cache_tracker #(
    parameter int BLOCK_BYTES      = lrut_pkg::BLOCK_BYTES_DEF,
    parameter int CACHE_SLOTS      = lrut_pkg::CACHE_SLOTS_DEF,
    parameter int BLOCK_INDEX_BITS = lrut_pkg::BLOCK_INDEX_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // block_number, start_offset, byte_count, fetched_size, 2 bits zero pad
    input  logic [lrut_pkg::S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [lrut_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot, writeback_block, writeback_size, 7 bits zero pad
    output logic [lrut_pkg::M_TDATA_W-1:0] m_tdata,
    // hit, writeback_valid
    output logic [lrut_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tlast
);
    import lrut_pkg::*;

    localparam int SLOT_W = $clog2(CACHE_SLOTS);
    localparam int TAG_W  = BLOCK_INDEX_BITS;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_UPDATE  = 5'b00100,
        ST_FL_FIND = 5'b01000,
        ST_FL_EMIT = 5'b10000
    } state_t;

    function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] v);
        clamp_ext = (32'(v) > 32'(BLOCK_BYTES)) ? EXT_W'(BLOCK_BYTES) : v;
    endfunction

    state_t state_reg, state_next;

    // Item registers
    logic              wr_item_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [START_W-1:0] start_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [FETCH_W-1:0] fetched_reg;

    // Sweep and lookup state
    logic [SLOT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic              hit_reg, hit_next;
    logic [SLOT_W-1:0] hit_slot_reg, hit_slot_next;
    logic [EXT_W-1:0]  hit_ext_reg, hit_ext_next;
    logic [TAG_W-1:0]  ev_tag_reg, ev_tag_next;
    logic [EXT_W-1:0]  ev_ext_reg, ev_ext_next;
    logic [SLOT_W-1:0] fl_rank_reg, fl_rank_next;
    logic [SLOT_W-1:0] fl_slot_reg, fl_slot_next;

    // Tag and extent RAM
    logic [TAG_W-1:0]  tag_mem [CACHE_SLOTS];
    logic [EXT_W-1:0]  ext_mem [CACHE_SLOTS];
    logic [TAG_W-1:0]  rd_tag_reg;
    logic [EXT_W-1:0]  rd_ext_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              mem_we;

    // Output register
    logic                    m_valid_reg, m_valid_next;
    logic                    m_hit_reg, m_hit_next;
    logic [SLOT_FIELD_W-1:0] m_slot_reg, m_slot_next;
    logic                    m_wbv_reg, m_wbv_next;
    logic [WB_BLOCK_W-1:0]   m_wbb_reg, m_wbb_next;
    logic [WB_SIZE_W-1:0]    m_wbs_reg, m_wbs_next;
    logic                    m_last_reg, m_last_next;

    // Recency table interface
    rcy_cmd_t          cmd;
    logic              free_found, probe_used, occ_zero;
    logic [SLOT_W-1:0] free_slot, lru_slot, rank_slot, last_rank;

    // Update decision
    logic [EXT_W-1:0]  fetched_c, span_c, count_c, upd_ext;
    logic [SLOT_W-1:0] upd_slot;
    logic              upd_wbv, upd_alloc;

    logic in_acc, out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    lrut_recency #(
        .CACHE_SLOTS(CACHE_SLOTS)
    ) u_recency (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cmd_slot  (upd_slot),
        .find_rank (fl_rank_reg),
        .probe_slot(cmp_idx_reg),
        .free_found(free_found),
        .free_slot (free_slot),
        .lru_slot  (lru_slot),
        .rank_slot (rank_slot),
        .probe_used(probe_used),
        .occ_zero  (occ_zero),
        .last_rank (last_rank)
    );

    // New extent and target slot once the sweep is done
    always_comb begin
        fetched_c = clamp_ext(EXT_W'(fetched_reg));
        span_c    = clamp_ext(EXT_W'(start_reg) + EXT_W'(count_reg));
        count_c   = clamp_ext(EXT_W'(count_reg));
        upd_wbv   = 1'b0;
        upd_alloc = 1'b0;
        if (hit_reg) begin
            upd_slot = hit_slot_reg;
            if (wr_item_reg) begin
                upd_ext = (span_c > hit_ext_reg) ? span_c : hit_ext_reg;
            end else if (32'(hit_ext_reg) < 32'(BLOCK_BYTES) && fetched_c != '0) begin
                upd_ext = fetched_c;
            end else begin
                upd_ext = hit_ext_reg;
            end
        end else begin
            if (!wr_item_reg) begin
                upd_ext = fetched_c;
            end else if (start_reg != '0) begin
                upd_ext = (fetched_c > span_c) ? fetched_c : span_c;
            end else begin
                upd_ext = count_c;
            end
            if (free_found) begin
                upd_slot  = free_slot;
                upd_alloc = 1'b1;
            end else begin
                upd_slot = lru_slot;
                upd_wbv  = 1'b1;
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = scan_cnt_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        hit_ext_next   = hit_ext_reg;
        ev_tag_next    = ev_tag_reg;
        ev_ext_next    = ev_ext_reg;
        fl_rank_next   = fl_rank_reg;
        fl_slot_next   = fl_slot_reg;
        rd_addr        = scan_cnt_reg;
        mem_we         = 1'b0;
        cmd            = '0;
        m_valid_next   = m_valid_reg && !m_tready;
        m_hit_next     = m_hit_reg;
        m_slot_next    = m_slot_reg;
        m_wbv_next     = m_wbv_reg;
        m_wbb_next     = m_wbb_reg;
        m_wbs_next     = m_wbs_reg;
        m_last_next    = m_last_reg;

        // Shared tag comparator on the word read last cycle
        if (cmp_valid_reg) begin
            if (probe_used && rd_tag_reg == tag_reg) begin
                hit_next      = 1'b1;
                hit_slot_next = cmp_idx_reg;
                hit_ext_next  = rd_ext_reg;
            end
            if (cmp_idx_reg == lru_slot) begin
                ev_tag_next = rd_tag_reg;
                ev_ext_next = rd_ext_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (s_tuser)
                        ACT_READ, ACT_WRITE: begin
                            state_next    = ST_SCAN;
                            scan_cnt_next = '0;
                            hit_next      = 1'b0;
                        end
                        ACT_FLUSH: begin
                            state_next   = ST_FL_FIND;
                            fl_rank_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                rd_addr        = scan_cnt_reg;
                cmp_valid_next = 1'b1;
                cmp_idx_next   = scan_cnt_reg;
                if (scan_cnt_reg == SLOT_W'(CACHE_SLOTS - 1)) begin
                    state_next = ST_UPDATE;
                end else begin
                    scan_cnt_next = scan_cnt_reg + SLOT_W'(1);
                end
            end
            ST_UPDATE: begin
                if (!cmp_valid_reg && out_free) begin
                    mem_we        = 1'b1;
                    cmd.promote   = 1'b1;
                    cmd.alloc     = upd_alloc;
                    m_valid_next  = 1'b1;
                    m_hit_next    = hit_reg;
                    m_slot_next   = SLOT_FIELD_W'(upd_slot);
                    m_wbv_next    = upd_wbv;
                    m_wbb_next    = upd_wbv ? WB_BLOCK_W'(ev_tag_reg) : '0;
                    m_wbs_next    = upd_wbv ? WB_SIZE_W'(ev_ext_reg) : '0;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FL_FIND: begin
                rd_addr      = rank_slot;
                fl_slot_next = rank_slot;
                if (occ_zero) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_hit_next   = 1'b0;
                        m_slot_next  = '0;
                        m_wbv_next   = 1'b0;
                        m_wbb_next   = '0;
                        m_wbs_next   = '0;
                        m_last_next  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    state_next = ST_FL_EMIT;
                end
            end
            ST_FL_EMIT: begin
                rd_addr = fl_slot_reg;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = 1'b0;
                    m_slot_next  = SLOT_FIELD_W'(fl_slot_reg);
                    m_wbv_next   = 1'b1;
                    m_wbb_next   = WB_BLOCK_W'(rd_tag_reg);
                    m_wbs_next   = WB_SIZE_W'(rd_ext_reg);
                    m_last_next  = (fl_rank_reg == last_rank);
                    if (fl_rank_reg == last_rank) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        fl_rank_next = fl_rank_reg + SLOT_W'(1);
                        state_next   = ST_FL_FIND;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            wr_item_reg <= (s_tuser == ACT_WRITE);
            tag_reg     <= TAG_W'(s_tdata[S_BLOCK_LSB +: BLOCK_NUM_W]);
            start_reg   <= s_tdata[S_START_LSB +: START_W];
            count_reg   <= s_tdata[S_COUNT_LSB +: COUNT_W];
            fetched_reg <= s_tdata[S_FETCH_LSB +: FETCH_W];
        end
        scan_cnt_reg <= scan_cnt_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_reg      <= hit_next;
        hit_slot_reg <= hit_slot_next;
        hit_ext_reg  <= hit_ext_next;
        ev_tag_reg   <= ev_tag_next;
        ev_ext_reg   <= ev_ext_next;
        fl_rank_reg  <= fl_rank_next;
        fl_slot_reg  <= fl_slot_next;
        m_hit_reg    <= m_hit_next;
        m_slot_reg   <= m_slot_next;
        m_wbv_reg    <= m_wbv_next;
        m_wbb_reg    <= m_wbb_next;
        m_wbs_reg    <= m_wbs_next;
        m_last_reg   <= m_last_next;
    end

    // Tag and extent RAM: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tag_mem[upd_slot] <= tag_reg;
            ext_mem[upd_slot] <= upd_ext;
        end
        rd_tag_reg <= tag_mem[rd_addr];
        rd_ext_reg <= ext_mem[rd_addr];
    end

    // Result word packing
    always_comb begin
        m_tdata                                = '0;
        m_tdata[M_SLOT_LSB +: SLOT_FIELD_W]    = m_slot_reg;
        m_tdata[M_WBB_LSB +: WB_BLOCK_W]       = m_wbb_reg;
        m_tdata[M_WBS_LSB +: WB_SIZE_W]        = m_wbs_reg;
        m_tuser                                = '0;
        m_tuser[M_HIT_BIT]                     = m_hit_reg;
        m_tuser[M_WBV_BIT]                     = m_wbv_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== hw/rtl/lrut_checker.sv =====
// Port-level checks of the LRU block cache tracker, bound to the top level.
module lrut_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [lrut_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lrut_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [lrut_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                           m_tlast
);
    import lrut_pkg::*;

    // An accepted access keeps the block busy for its tag sweep
    a_access_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ACT_READ || s_tuser == ACT_WRITE)
        |=> !s_tready)
        else $error("input taken during access sweep");

    // Only flush write-backs may be non-final words
    a_nonlast_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[M_WBV_BIT] && !m_tuser[M_HIT_BIT])
        else $error("non-final word is not a flush write-back");

    // A hit never evicts
    a_hit_no_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[M_HIT_BIT] && m_tuser[M_WBV_BIT]))
        else $error("hit reported together with write-back");

    // Without write-back the block and size fields are zero
    a_no_wb_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[M_WBV_BIT]
        |-> m_tdata[M_WBB_LSB +: WB_BLOCK_W + WB_SIZE_W] == '0)
        else $error("write-back fields set without write-back");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready
        |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result word changed");

endmodule

bind lru_block_cache_tracker lrut_checker u_lrut_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
